// ===== hw/rtl/bblc_pkg.sv =====
// Shared types and field widths for the byte budget LRU cache unit.
`default_nettype none

package bblc_pkg;

    localparam int KEY_W   = 32;
    localparam int SIZE_W  = 40;
    localparam int EVICT_W = 7;
    localparam int HALF_W  = 16;
    localparam logic [SIZE_W-1:0] LIMIT_RESET = 40'd268435456;
    localparam logic [EVICT_W-1:0] EVICT_MAX = 7'd127;

    typedef struct packed {
        logic                hit;
        logic                inserted;
        logic [EVICT_W-1:0]  evicted_count;
        logic [SIZE_W-1:0]   used_bytes;
    } bblc_result_t;

endpackage

`default_nettype wire

// ===== hw/rtl/bblc_ram.sv =====
// Single-port-write, single-port-read synchronous RAM with registered read data.
`default_nettype none

module bblc_ram #(
    parameter int DEPTH  = 64,
    parameter int DATA_W = 79
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [DATA_W-1:0]        wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [DATA_W-1:0]        rdata
);

    logic [DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/bblc_engine.sv =====
// Sweep sequencer that looks up, touches, evicts and inserts cache entries in the table RAM.
`default_nettype none

module bblc_engine
    import bblc_pkg::*;
#(
    parameter int ENTRIES = 64
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic [HALF_W-1:0]  expert_index,
    input  wire logic [HALF_W-1:0]  context_tag,
    input  wire logic [SIZE_W-1:0]  raw_bytes,
    input  wire logic [SIZE_W-1:0]  reserve_bytes,
    input  wire logic               alloc_ok,
    input  wire logic [SIZE_W-1:0]  alloc_bytes,
    input  wire logic [SIZE_W-1:0]  byte_limit,
    input  wire logic               out_free,
    output logic                    done,
    output bblc_result_t            result
);

    localparam int IW    = $clog2(ENTRIES);
    localparam int CW    = $clog2(ENTRIES + 1);
    localparam int RW    = IW;
    localparam int S_LO  = RW;
    localparam int K_LO  = RW + SIZE_W;
    localparam int V_BIT = RW + SIZE_W + KEY_W;
    localparam int DW    = V_BIT + 1;

    typedef enum logic [3:0] {
        ST_CLEAR, ST_IDLE, ST_LOOKUP, ST_TOUCH, ST_FIT, ST_EVICT, ST_INSERT, ST_DONE
    } state_t;

    state_t              state_reg, state_next;
    logic [CW-1:0]       cnt_reg, cnt_next;
    logic                rd_vld_reg, rd_vld_next;
    logic [IW-1:0]       rd_idx_reg, rd_idx_next;
    logic [KEY_W-1:0]    key_reg, key_next;
    logic [SIZE_W-1:0]   raw_reg, raw_next;
    logic [SIZE_W-1:0]   res_reg, res_next;
    logic                ok_reg, ok_next;
    logic [SIZE_W-1:0]   act_reg, act_next;
    logic [SIZE_W-1:0]   total_reg, total_next;
    logic [CW-1:0]       live_reg, live_next;
    logic [EVICT_W-1:0]  ev_reg, ev_next;
    logic                hit_reg, hit_next;
    logic                ins_reg, ins_next;
    logic                found_reg, found_next;
    logic [IW-1:0]       hit_idx_reg, hit_idx_next;
    logic [RW-1:0]       hit_rank_reg, hit_rank_next;
    logic [1:0]          phase_reg, phase_next;

    logic                we, re;
    logic [IW-1:0]       waddr;
    logic [DW-1:0]       wdata, rdata;
    logic                r_valid;
    logic [KEY_W-1:0]    r_key;
    logic [SIZE_W-1:0]   r_size;
    logic [RW-1:0]       r_rank;
    logic                last;
    logic [SIZE_W-1:0]   fit_size;
    logic [SIZE_W:0]     fit_sum;
    logic                over;

    bblc_ram #(
        .DEPTH  (ENTRIES),
        .DATA_W (DW)
    ) u_ram (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .re    (re),
        .raddr (cnt_reg[IW-1:0]),
        .rdata (rdata)
    );

    assign r_valid = rdata[V_BIT];
    assign r_key   = rdata[K_LO +: KEY_W];
    assign r_size  = rdata[S_LO +: SIZE_W];
    assign r_rank  = rdata[RW-1:0];
    assign last    = rd_vld_reg && (rd_idx_reg == IW'(ENTRIES - 1));

    assign fit_size = (phase_reg == 2'd0) ? res_reg : act_reg;
    assign fit_sum  = {1'b0, total_reg} + {1'b0, fit_size};
    assign over     = fit_sum > {1'b0, byte_limit};

    assign in_stall = (state_reg != ST_IDLE);
    assign result   = '{hit: hit_reg, inserted: ins_reg, evicted_count: ev_reg,
                        used_bytes: total_reg};

    always_comb
    begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        key_next      = key_reg;
        raw_next      = raw_reg;
        res_next      = res_reg;
        ok_next       = ok_reg;
        act_next      = act_reg;
        total_next    = total_reg;
        live_next     = live_reg;
        ev_next       = ev_reg;
        hit_next      = hit_reg;
        ins_next      = ins_reg;
        found_next    = found_reg;
        hit_idx_next  = hit_idx_reg;
        hit_rank_next = hit_rank_reg;
        phase_next    = phase_reg;
        we            = 1'b0;
        waddr         = rd_idx_reg;
        wdata         = rdata;
        re            = 1'b0;
        done          = 1'b0;

        if (state_reg == ST_LOOKUP || state_reg == ST_TOUCH ||
            state_reg == ST_EVICT || state_reg == ST_INSERT)
        begin
            re = cnt_reg < CW'(ENTRIES);
            if (re)
            begin
                cnt_next = cnt_reg + 1'b1;
            end
        end
        rd_vld_next = re;
        rd_idx_next = cnt_reg[IW-1:0];

        unique case (state_reg)
            ST_CLEAR:
            begin
                we       = 1'b1;
                waddr    = cnt_reg[IW-1:0];
                wdata    = '0;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CW'(ENTRIES - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    key_next   = {expert_index, context_tag};
                    raw_next   = raw_bytes;
                    res_next   = reserve_bytes;
                    ok_next    = alloc_ok;
                    act_next   = alloc_bytes;
                    ev_next    = '0;
                    hit_next   = 1'b0;
                    ins_next   = 1'b0;
                    found_next = 1'b0;
                    cnt_next   = '0;
                    state_next = ST_LOOKUP;
                end
            end
            ST_LOOKUP:
            begin
                if (rd_vld_reg && r_valid && r_key == key_reg && !found_reg)
                begin
                    found_next    = 1'b1;
                    hit_idx_next  = rd_idx_reg;
                    hit_rank_next = r_rank;
                end
                if (last)
                begin
                    cnt_next   = '0;
                    phase_next = 2'd0;
                    if (found_next)
                    begin
                        hit_next   = 1'b1;
                        state_next = ST_TOUCH;
                    end
                    else if (byte_limit != '0 && raw_reg <= byte_limit &&
                             res_reg <= byte_limit)
                    begin
                        state_next = ST_FIT;
                    end
                    else
                    begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_TOUCH:
            begin
                if (rd_vld_reg && r_valid)
                begin
                    if (rd_idx_reg == hit_idx_reg)
                    begin
                        we    = 1'b1;
                        wdata = {rdata[DW-1:RW], {RW{1'b0}}};
                    end
                    else if (r_rank < hit_rank_reg)
                    begin
                        we    = 1'b1;
                        wdata = {rdata[DW-1:RW], r_rank + 1'b1};
                    end
                end
                if (last)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_FIT:
            begin
                cnt_next   = '0;
                found_next = 1'b0;
                if (phase_reg == 2'd2)
                begin
                    state_next = ST_INSERT;
                end
                else if (live_reg != '0 && over)
                begin
                    state_next = ST_EVICT;
                end
                else if (phase_reg == 2'd0)
                begin
                    if (ok_reg && act_reg <= byte_limit)
                    begin
                        phase_next = 2'd1;
                    end
                    else
                    begin
                        state_next = ST_DONE;
                    end
                end
                else if (live_reg == CW'(ENTRIES))
                begin
                    phase_next = 2'd2;
                    state_next = ST_EVICT;
                end
                else
                begin
                    state_next = ST_INSERT;
                end
            end
            ST_EVICT:
            begin
                if (rd_vld_reg && r_valid && !found_reg &&
                    r_rank == RW'(live_reg - 1'b1))
                begin
                    we         = 1'b1;
                    wdata      = {1'b0, rdata[DW-2:0]};
                    found_next = 1'b1;
                    total_next = total_reg - r_size;
                    live_next  = live_reg - 1'b1;
                    if (ev_reg != EVICT_MAX)
                    begin
                        ev_next = ev_reg + 1'b1;
                    end
                end
                if (last)
                begin
                    state_next = ST_FIT;
                end
            end
            ST_INSERT:
            begin
                if (rd_vld_reg)
                begin
                    if (r_valid)
                    begin
                        we    = 1'b1;
                        wdata = {rdata[DW-1:RW], r_rank + 1'b1};
                    end
                    else if (!found_reg)
                    begin
                        we         = 1'b1;
                        wdata      = {1'b1, key_reg, act_reg, {RW{1'b0}}};
                        found_next = 1'b1;
                        total_next = total_reg + act_reg;
                        live_next  = live_reg + 1'b1;
                        ins_next   = 1'b1;
                    end
                end
                if (last)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    done       = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_CLEAR;
            cnt_reg    <= '0;
            rd_vld_reg <= 1'b0;
            total_reg  <= '0;
            live_reg   <= '0;
            ev_reg     <= '0;
            hit_reg    <= 1'b0;
            ins_reg    <= 1'b0;
            found_reg  <= 1'b0;
            phase_reg  <= 2'd0;
        end
        else
        begin
            state_reg  <= state_next;
            cnt_reg    <= cnt_next;
            rd_vld_reg <= rd_vld_next;
            total_reg  <= total_next;
            live_reg   <= live_next;
            ev_reg     <= ev_next;
            hit_reg    <= hit_next;
            ins_reg    <= ins_next;
            found_reg  <= found_next;
            phase_reg  <= phase_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_idx_reg   <= rd_idx_next;
        key_reg      <= key_next;
        raw_reg      <= raw_next;
        res_reg      <= res_next;
        ok_reg       <= ok_next;
        act_reg      <= act_next;
        hit_idx_reg  <= hit_idx_next;
        hit_rank_reg <= hit_rank_next;
    end

    a_live_bound: assert property (@(posedge clk) disable iff (!rst_n)
        live_reg <= CW'(ENTRIES))
        else $error("live entry count exceeds table depth");

    a_hit_no_insert: assert property (@(posedge clk) disable iff (!rst_n)
        !(hit_reg && ins_reg))
        else $error("a hit also reported an insertion");

    a_no_rw_clash: assert property (@(posedge clk) disable iff (!rst_n)
        !(we && re && waddr == cnt_reg[IW-1:0]))
        else $error("read and write of the same entry in one cycle");

    a_done_only_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> out_free)
        else $error("result produced while output register is occupied");

endmodule

`default_nettype wire

// ===== hw/rtl/byte_budget_lru_cache_unit.sv =====
// Top level of the byte budget LRU cache unit: limit register, result register and engine.
//
// The unit keeps a directory of up to ENTRIES cached slices in one synchronous RAM and
// answers each request beat with one result beat. Lookup, recency update, eviction and
// insertion are each a full sweep of that RAM, one entry per cycle. A hit runs a lookup
// sweep and a recency update sweep, then hands off its result and returns to idle. A miss
// that inserts after k evictions runs a lookup sweep, k evictions and an insertion sweep,
// and every eviction is one decision in the fit state plus one sweep. A miss rejected by
// the lookup checks ends after the lookup sweep, and a miss rejected later also pays for
// its decisions and the evictions already made. After reset the RAM is cleared, and no
// request is taken until the clear is done. A finished result waits in its own register,
// so the next request can be taken while the previous result is still stalled; a second
// finished result waits in the engine until that register frees up.
`default_nettype none

module byte_budget_lru_cache_unit
    import bblc_pkg::*;
#(
    parameter int ENTRIES = 64
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic [SIZE_W-1:0]  cfg_data,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic [HALF_W-1:0]  expert_index,
    input  wire logic [HALF_W-1:0]  context_tag,
    input  wire logic [SIZE_W-1:0]  raw_bytes,
    input  wire logic [SIZE_W-1:0]  reserve_bytes,
    input  wire logic               alloc_ok,
    input  wire logic [SIZE_W-1:0]  alloc_bytes,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic                    hit,
    output logic                    inserted,
    output logic [EVICT_W-1:0]      evicted_count,
    output logic [SIZE_W-1:0]       used_bytes
);

    logic [SIZE_W-1:0] limit_reg;
    logic              out_valid_reg;
    bblc_result_t      out_reg;
    bblc_result_t      result;
    logic              done;
    logic              out_free;

    assign cfg_ready = 1'b1;
    assign out_free  = !out_valid_reg || !out_stall;

    bblc_engine #(
        .ENTRIES (ENTRIES)
    ) u_engine (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .expert_index  (expert_index),
        .context_tag   (context_tag),
        .raw_bytes     (raw_bytes),
        .reserve_bytes (reserve_bytes),
        .alloc_ok      (alloc_ok),
        .alloc_bytes   (alloc_bytes),
        .byte_limit    (limit_reg),
        .out_free      (out_free),
        .done          (done),
        .result        (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg     <= LIMIT_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                limit_reg <= cfg_data;
            end
            if (done)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (done)
        begin
            out_reg <= result;
        end
    end

    assign out_valid     = out_valid_reg;
    assign hit           = out_reg.hit;
    assign inserted      = out_reg.inserted;
    assign evicted_count = out_reg.evicted_count;
    assign used_bytes    = out_reg.used_bytes;

endmodule

`default_nettype wire
